[rtl/core/bba_pkg.sv]
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  localparam int NUM_BLOCKS  = 4096;
  localparam int BLK_AW      = 12;
  localparam int BLOCK_SHIFT = 6;
  localparam int WORD_BITS   = 8;
  localparam int NUM_WORDS   = NUM_BLOCKS / WORD_BITS;
  localparam int WORD_AW     = 9;
  localparam int CNT_W       = 13;
  localparam int CLR_SWEEP   = NUM_WORDS;

  localparam logic       OP_ALLOC  = 1'b0;
  localparam logic       OP_FREE   = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSPC  = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_SCAN_RD, S_SCAN, S_MARK_RD, S_MARK, S_DONE, S_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic prep;
    logic scan_rd;
    logic scan_bit;
    logic mark_rd;
    logic mark_bit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_alloc;
    logic early_fail;
    logic scan_found;
    logic scan_end;
    logic word_end;
    logic mark_end;
    logic mark_word_end;
  } stat_t;

endpackage

[rtl/core/bba_ctrl.sv]
// Controller state machine of the bitmap block allocator.
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bba_pkg::stat_t st,
  output bba_pkg::cmd_t  cmd
);
  import bba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (!st.is_alloc)       state_nxt = S_MARK_RD;
        else if (st.early_fail) state_nxt = S_DONE;
        else                    state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_bit = 1'b1;
        if (st.scan_found)    state_nxt = S_MARK_RD;
        else if (st.scan_end) state_nxt = S_DONE;
        else if (st.word_end) state_nxt = S_SCAN_RD;
      end
      S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        if (st.mark_end) state_nxt = S_DONE;
        else             state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark_bit = 1'b1;
        if (st.mark_end || st.mark_word_end) state_nxt = S_MARK_RD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/bba_dp.sv]
// Datapath of the bitmap block allocator: occupancy memory, scan and mark counters.
module bba_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bba_pkg::cmd_t        cmd,
  output bba_pkg::stat_t       st,
  input  logic                 in_opcode,
  input  logic [18:0]          in_size_bytes,
  input  logic [4:0]           in_align_shift,
  input  logic [17:0]          in_offset_bytes,
  output logic [1:0]           out_status,
  output logic [17:0]          out_alloc_offset,
  output logic [18:0]          out_granted_bytes,
  output logic [18:0]          out_used_bytes,
  output logic                 out_now_empty
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  logic             op_r;
  logic [18:0]      size_r;
  logic [4:0]       shift_r;
  logic [17:0]      offs_r;
  logic [CNT_W-1:0] need_r;
  logic [CNT_W-1:0] used_r;
  logic [BLK_AW:0]  pos_r;     // scan position; doubles as clear pointer
  logic [BLK_AW:0]  run_r;
  logic [BLK_AW-1:0] first_r;
  logic [BLK_AW:0]  mpos_r;    // next block to write in mark/free
  logic [CNT_W-1:0] mleft_r;   // blocks remaining in mark/free
  logic             set_r;     // 1 marks used, 0 clears
  logic             fail_r;
  logic             under_r;
  logic [WORD_BITS-1:0] word_r;

  logic [13:0] need_calc;
  logic [12:0] free_n;
  logic [BLK_AW-1:0] bpos;
  logic [18:0] bofs;
  logic        aligned;
  logic [BLK_AW:0] run_new;
  logic        bit_v;

  logic [BLK_AW-1:0] first_out;
  logic [BLK_AW-1:0] grant_r;

  assign need_calc = 14'((20'(size_r) + 20'd63) >> BLOCK_SHIFT);
  assign free_n    = size_r[18:BLOCK_SHIFT];
  assign bpos      = pos_r[BLK_AW-1:0];
  assign bofs      = {1'b0, bpos, 6'd0};
  assign aligned   = ((bofs & 19'((20'd1 << shift_r) - 20'd1)) == 19'd0) || shift_r > 5'd18
                     ? (shift_r > 5'd18 ? (bpos == '0) : 1'b1) : 1'b0;
  assign bit_v     = word_r[pos_r[2:0]];
  always_comb begin
    if (bit_v)             run_new = '0;
    else if (run_r == '0)  run_new = aligned ? (BLK_AW+1)'(1) : '0;
    else                   run_new = run_r + 1'b1;
  end

  assign st.clear_done    = (pos_r == (BLK_AW+1)'(CLR_SWEEP - 1));
  assign st.is_alloc      = (op_r == OP_ALLOC);
  assign st.early_fail    = (need_calc == 14'd0) || (need_calc > 14'(NUM_BLOCKS));
  assign st.scan_found    = (run_new != '0) && (run_new == (BLK_AW+1)'(need_r));
  assign st.scan_end      = (pos_r == (BLK_AW+1)'(NUM_BLOCKS - 1));
  assign st.word_end      = (pos_r[2:0] == 3'd7);
  assign st.mark_end      = (mleft_r == '0) || mpos_r[BLK_AW];
  assign st.mark_word_end = (mpos_r[2:0] == 3'd7);

  // Memory: one read and one write port, read data registered.
  logic [WORD_AW-1:0] waddr;
  logic [WORD_BITS-1:0] wdata;
  logic we;
  logic [WORD_AW-1:0] raddr;
  logic dirty_r;

  always_comb begin
    we    = 1'b0;
    waddr = mpos_r[BLK_AW-1:3];
    wdata = word_r;
    raddr = cmd.scan_rd ? pos_r[BLK_AW-1:3] : mpos_r[BLK_AW-1:3];
    if (cmd.clear_step) begin
      we = 1'b1; waddr = pos_r[WORD_AW-1:0]; wdata = '0;
    end else if (cmd.mark_rd && dirty_r) begin
      we = 1'b1; waddr = 9'(({1'b0, mpos_r} - 1'b1) >> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.scan_rd || cmd.mark_rd) word_r <= mem[raddr];
    else if (cmd.mark_bit && !st.mark_end) word_r[mpos_r[2:0]] <= set_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      pos_r   <= '0;
      dirty_r <= 1'b0;
    end else begin
      if (cmd.clear_step) pos_r <= pos_r + 1'b1;
      if (cmd.load) begin
        op_r <= in_opcode; size_r <= in_size_bytes;
        shift_r <= in_align_shift; offs_r <= in_offset_bytes;
        fail_r <= 1'b0; under_r <= 1'b0; dirty_r <= 1'b0;
      end
      if (cmd.prep) begin
        pos_r <= '0; run_r <= '0; set_r <= (op_r == OP_ALLOC);
        need_r <= CNT_W'(need_calc);
        if (op_r == OP_ALLOC) begin
          fail_r <= (need_calc == 14'd0) || (need_calc > 14'(NUM_BLOCKS));
        end else if (free_n > used_r) begin
          under_r <= 1'b1; mleft_r <= '0; mpos_r <= '0;
        end else begin
          mleft_r <= free_n; mpos_r <= {1'b0, offs_r[17:BLOCK_SHIFT]};
          used_r  <= used_r - free_n;
        end
      end
      if (cmd.scan_bit) begin
        run_r <= run_new;
        pos_r <= pos_r + 1'b1;
        if (run_new == (BLK_AW+1)'(1)) first_r <= bpos;
        if (st.scan_found) begin
          mpos_r  <= {1'b0, (run_new == (BLK_AW+1)'(1)) ? bpos : first_r};
          mleft_r <= need_r;
          used_r  <= used_r + need_r;
        end else if (st.scan_end) fail_r <= 1'b1;
      end
      if (cmd.mark_rd) dirty_r <= 1'b0;
      if (cmd.mark_bit && !st.mark_end) begin
        mpos_r <= mpos_r + 1'b1; mleft_r <= mleft_r - 1'b1; dirty_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_status <= fail_r ? ST_NOSPC : (under_r ? ST_UNDER : ST_OK);
        out_alloc_offset  <= (op_r == OP_ALLOC && !fail_r) ? {first_out, 6'd0} : '0;
        out_granted_bytes <= (op_r == OP_ALLOC && !fail_r) ? {need_r, 6'd0} : '0;
        out_used_bytes    <= {used_r, 6'd0};
        out_now_empty     <= (op_r == OP_FREE) && !under_r && (used_r == '0);
      end
    end
  end

  // Start block of the granted run, held from the scan for the result.
  always_ff @(posedge clk) begin
    if (cmd.scan_bit && st.scan_found)
      grant_r <= (run_new == (BLK_AW+1)'(1)) ? bpos : first_r;
  end
  assign first_out = grant_r;

endmodule

[rtl/core/bitmap_block_allocator.sv]
// Top level of the bitmap first-fit block allocator.
// Bitmap allocator for 4096 blocks of 64 bytes each. It takes one request
// at a time. After reset it clears the map and takes no request until
// then. An allocate scans the map one bit per cycle from block 0, pausing
// to read each byte-wide word of the map, and then marks the blocks it
// grants. A free clears the bits of the blocks it releases. Both the scan
// and the marking step bit by bit through the byte-wide occupancy memory.
module bitmap_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [18:0] in_size_bytes,
  input  logic [4:0]  in_align_shift,
  input  logic [17:0] in_offset_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [17:0] out_alloc_offset,
  output logic [18:0] out_granted_bytes,
  output logic [18:0] out_used_bytes,
  output logic        out_now_empty
);
  import bba_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bba_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
  );

  bba_dp u_dp (
    .clk, .rst_n, .cmd, .st, .in_opcode, .in_size_bytes, .in_align_shift,
    .in_offset_bytes, .out_status, .out_alloc_offset, .out_granted_bytes,
    .out_used_bytes, .out_now_empty
  );

endmodule
